// File: sv/nld_pkg.sv
// Shared types, character codes and digit helpers for the numeric literal decoder.
package nld_pkg;

   // Radix codes as reported on the result channel.
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;
   localparam logic [1:0] RADIX_BIN = 2'd3;

   // Lexer modes.
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_ZERO = 2'd1;
   localparam logic [1:0] MODE_INT  = 2'd2;
   localparam logic [1:0] MODE_FRAC = 2'd3;

   // Character codes.
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_ONE     = 8'h31;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_F = 8'h66;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_F = 8'h46;
   localparam logic [7:0] CHR_LOWER_X = 8'h78;
   localparam logic [7:0] CHR_UPPER_X = 8'h58;
   localparam logic [7:0] CHR_LOWER_O = 8'h6f;
   localparam logic [7:0] CHR_UPPER_O = 8'h4f;
   localparam logic [7:0] CHR_LOWER_B = 8'h62;
   localparam logic [7:0] CHR_UPPER_B = 8'h42;
   localparam logic [7:0] CHR_POINT   = 8'h2e;

   localparam int INT_WIDTH    = 64;
   localparam int FRAC_WIDTH   = 32;
   localparam int ACC_WIDTH    = 48;
   localparam int WEIGHT_WIDTH = 49;

   localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;

   // Weight of the k-th decimal fraction digit: floor(2^48 / 10^k).
   localparam logic [WEIGHT_WIDTH-1:0] DEC_WEIGHT [16] = '{
      49'(ONE_Q48 / 64'd1),
      49'(ONE_Q48 / 64'd10),
      49'(ONE_Q48 / 64'd100),
      49'(ONE_Q48 / 64'd1000),
      49'(ONE_Q48 / 64'd10000),
      49'(ONE_Q48 / 64'd100000),
      49'(ONE_Q48 / 64'd1000000),
      49'(ONE_Q48 / 64'd10000000),
      49'(ONE_Q48 / 64'd100000000),
      49'(ONE_Q48 / 64'd1000000000),
      49'(ONE_Q48 / 64'd10000000000),
      49'(ONE_Q48 / 64'd100000000000),
      49'(ONE_Q48 / 64'd1000000000000),
      49'(ONE_Q48 / 64'd10000000000000),
      49'(ONE_Q48 / 64'd100000000000000),
      49'(ONE_Q48 / 64'd1000000000000000)
   };

   typedef struct packed {
      logic [INT_WIDTH-1:0]  integer_value;
      logic [FRAC_WIDTH-1:0] fraction;
      logic                  has_point;
      logic [1:0]            radix_code;
   } nld_result_type;

   // Returns {is_digit, value} for a character in the given radix.
   function automatic logic [4:0] digit_value(input logic [7:0] c, input logic [1:0] radix);
      logic       any;
      logic [3:0] v;
      logic       ok;
      any = 1'b1;
      v   = 4'd0;
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
         v = 4'(c - CHR_ZERO);
      end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) begin
         v = 4'(c - CHR_LOWER_A) + 4'd10;
      end else if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) begin
         v = 4'(c - CHR_UPPER_A) + 4'd10;
      end else begin
         any = 1'b0;
      end
      case (radix)
         RADIX_DEC: ok = any && (v < 4'd10);
         RADIX_HEX: ok = any;
         RADIX_OCT: ok = any && (v < 4'd8);
         RADIX_BIN: ok = any && (v < 4'd2);
         default:   ok = 1'b0;
      endcase
      return {ok, v};
   endfunction

   // Integer accumulator times the radix, modulo 2^64.
   function automatic logic [INT_WIDTH-1:0] scale_int(input logic [INT_WIDTH-1:0] acc,
                                                      input logic [1:0] radix);
      logic [INT_WIDTH-1:0] r;
      case (radix)
         RADIX_DEC: r = (acc << 3) + (acc << 1);
         RADIX_HEX: r = acc << 4;
         RADIX_OCT: r = acc << 3;
         RADIX_BIN: r = acc << 1;
         default:   r = acc;
      endcase
      return r;
   endfunction

endpackage

// File: sv/numeric_literal_decoder.sv
// Numeric literal decoder: request register, lexer step and result register.
//
// Requests carry one ASCII character on req_chr and are taken when req_valid
// and req_ready are both high. Decimal, 0x/0o/0b prefixed literals and a
// fractional part after '.' are recognized. The character that ends a
// literal produces one result on the rsp_ channel (integer value modulo 2^64,
// Q0.32 fraction, point flag and radix code) and is then examined as the
// possible start of the next literal. Other characters produce no result.
// A literal still open at the end of the stream is not reported until a
// terminating character arrives.
// Path: request register, lexer step, result register.
// Throughput: one request per cycle unless the receiver stalls the result
// register; the lexer state update is a single step between the two registers.
// Reset clears the lexer state and both registers' valid flags.
// When the receiver holds rsp_ready low with a result waiting, the lexer
// stalls on the next request and req_ready drops once the request register
// is also occupied.
module numeric_literal_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_chr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_integer_value,
   output logic [31:0] rsp_fraction,
   output logic        rsp_has_point,
   output logic [1:0]  rsp_radix_code
);

   logic                    in_valid_ff;
   logic [7:0]              in_chr_ff;
   logic                    out_valid_ff;
   nld_pkg::nld_result_type out_ff;
   logic                    step;
   logic                    emit;
   nld_pkg::nld_result_type result;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   nld_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .chr     (in_chr_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_chr_ff <= req_chr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_integer_value = out_ff.integer_value;
   assign rsp_fraction      = out_ff.fraction;
   assign rsp_has_point     = out_ff.has_point;
   assign rsp_radix_code    = out_ff.radix_code;

endmodule

// File: sv/nld_core.sv
// Lexer state and the combinational step that consumes one character.
module nld_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              chr,
   output logic                    emit,
   output nld_pkg::nld_result_type result
);

   logic [1:0]                         mode_ff, mode_in;
   logic [1:0]                         radix_ff, radix_in;
   logic [nld_pkg::INT_WIDTH-1:0]      int_ff, int_in;
   logic [nld_pkg::ACC_WIDTH-1:0]      frac_ff, frac_in;
   logic [nld_pkg::WEIGHT_WIDTH-1:0]   weight_ff, weight_in;
   logic [3:0]                         count_ff, count_in;

   logic [4:0]                         dig;
   logic                               done;
   logic                               emit_v;
   logic [3:0]                         count_next;
   logic [nld_pkg::WEIGHT_WIDTH-1:0]   w_next;
   logic [nld_pkg::WEIGHT_WIDTH+3:0]   prod;

   always_comb begin
      mode_in   = mode_ff;
      radix_in  = radix_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      weight_in = weight_ff;
      count_in  = count_ff;
      done      = 1'b0;
      emit_v    = 1'b0;
      result    = '0;

      // After a leading zero, a prefix letter picks the radix; anything else
      // makes the literal decimal and falls through as its next character.
      if (mode_in == nld_pkg::MODE_ZERO) begin
         mode_in = nld_pkg::MODE_INT;
         if (chr == nld_pkg::CHR_LOWER_X || chr == nld_pkg::CHR_UPPER_X) begin
            radix_in = nld_pkg::RADIX_HEX;
            done     = 1'b1;
         end else if (chr == nld_pkg::CHR_LOWER_O || chr == nld_pkg::CHR_UPPER_O) begin
            radix_in = nld_pkg::RADIX_OCT;
            done     = 1'b1;
         end else if (chr == nld_pkg::CHR_LOWER_B || chr == nld_pkg::CHR_UPPER_B) begin
            radix_in = nld_pkg::RADIX_BIN;
            done     = 1'b1;
         end else begin
            radix_in = nld_pkg::RADIX_DEC;
         end
      end

      dig        = nld_pkg::digit_value(chr, radix_in);
      count_next = (count_ff == 4'd15) ? count_ff : count_ff + 4'd1;
      case (radix_in)
         nld_pkg::RADIX_DEC: w_next = nld_pkg::DEC_WEIGHT[count_next];
         nld_pkg::RADIX_HEX: w_next = weight_ff >> 4;
         nld_pkg::RADIX_OCT: w_next = weight_ff >> 3;
         default:            w_next = weight_ff >> 1;
      endcase
      prod = w_next * dig[3:0];

      if (!done && (mode_in == nld_pkg::MODE_INT || mode_in == nld_pkg::MODE_FRAC)) begin
         if (dig[4]) begin
            if (mode_in == nld_pkg::MODE_INT) begin
               int_in = nld_pkg::scale_int(int_in, radix_in) + 64'(dig[3:0]);
            end else begin
               weight_in = w_next;
               count_in  = count_next;
               frac_in   = frac_ff + prod[nld_pkg::ACC_WIDTH-1:0];
            end
            done = 1'b1;
         end else if (mode_in == nld_pkg::MODE_INT && chr == nld_pkg::CHR_POINT) begin
            mode_in   = nld_pkg::MODE_FRAC;
            frac_in   = '0;
            weight_in = nld_pkg::ONE_Q48[nld_pkg::WEIGHT_WIDTH-1:0];
            count_in  = '0;
            done      = 1'b1;
         end else begin
            // The literal ends here; the character is then seen as idle input.
            emit_v               = 1'b1;
            result.integer_value = int_in;
            result.has_point     = (mode_in == nld_pkg::MODE_FRAC);
            result.fraction      = (mode_in == nld_pkg::MODE_FRAC) ?
                                   frac_ff[nld_pkg::ACC_WIDTH-1:16] : '0;
            result.radix_code    = radix_in;
            mode_in              = nld_pkg::MODE_IDLE;
         end
      end

      if (!done) begin
         if (chr == nld_pkg::CHR_ZERO || (chr >= nld_pkg::CHR_ONE && chr <= nld_pkg::CHR_NINE)) begin
            radix_in  = nld_pkg::RADIX_DEC;
            int_in    = 64'(chr - nld_pkg::CHR_ZERO);
            frac_in   = '0;
            weight_in = nld_pkg::ONE_Q48[nld_pkg::WEIGHT_WIDTH-1:0];
            count_in  = '0;
            mode_in   = (chr == nld_pkg::CHR_ZERO) ? nld_pkg::MODE_ZERO : nld_pkg::MODE_INT;
         end
      end
   end

   assign emit = step_en && emit_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= nld_pkg::MODE_IDLE;
         radix_ff  <= nld_pkg::RADIX_DEC;
         int_ff    <= '0;
         frac_ff   <= '0;
         weight_ff <= nld_pkg::ONE_Q48[nld_pkg::WEIGHT_WIDTH-1:0];
         count_ff  <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         radix_ff  <= radix_in;
         int_ff    <= int_in;
         frac_ff   <= frac_in;
         weight_ff <= weight_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: tb/sv/numeric_literal_decoder_tb.sv
// Self-checking testbench for the numeric literal decoder: directed rows, then random literals.
`timescale 1ns / 100ps

module numeric_literal_decoder_tb;

   localparam int STALL_LIMIT     = 2000;
   localparam int CHARS_PER_PHASE = 310;
   localparam int HOLD_CYCLES     = 80;
   localparam int MAX_PRINTED     = 20;

   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_SEMI    = 8'h3b;
   localparam logic [7:0] CHR_LOWER_G = 8'h67;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7a;

   typedef struct packed {
      logic [7:0]              chr;
      logic                    typed;
      nld_pkg::nld_result_type res;
   } lit_row_type;

   localparam lit_row_type DIRECTED_ROWS [26] = '{
      '{8'h00, 1'b0, '0},
      '{nld_pkg::CHR_POINT, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{nld_pkg::CHR_ZERO, 1'b0, '0},
      '{nld_pkg::CHR_LOWER_X, 1'b0, '0},
      '{CHR_LOWER_G, 1'b1, '{64'd0, 32'd0, 1'b0, nld_pkg::RADIX_HEX}},
      '{nld_pkg::CHR_ZERO + 8'd7, 1'b0, '0},
      '{CHR_SPACE, 1'b1, '{64'd7, 32'd0, 1'b0, nld_pkg::RADIX_DEC}},
      '{nld_pkg::CHR_ZERO, 1'b0, '0},
      '{nld_pkg::CHR_UPPER_O, 1'b0, '0},
      '{nld_pkg::CHR_ZERO + 8'd7, 1'b0, '0},
      '{nld_pkg::CHR_ZERO + 8'd7, 1'b0, '0},
      '{nld_pkg::CHR_POINT, 1'b0, '0},
      '{nld_pkg::CHR_ZERO + 8'd4, 1'b0, '0},
      '{nld_pkg::CHR_POINT, 1'b1, '{64'd63, 32'h8000_0000, 1'b1, nld_pkg::RADIX_OCT}},
      '{nld_pkg::CHR_ZERO, 1'b0, '0},
      '{nld_pkg::CHR_UPPER_B, 1'b0, '0},
      '{nld_pkg::CHR_ONE, 1'b0, '0},
      '{nld_pkg::CHR_ZERO + 8'd2, 1'b1, '{64'd1, 32'd0, 1'b0, nld_pkg::RADIX_BIN}},
      '{nld_pkg::CHR_POINT, 1'b0, '0},
      '{nld_pkg::CHR_ZERO + 8'd5, 1'b0, '0},
      '{nld_pkg::CHR_ZERO, 1'b0, '0},
      '{nld_pkg::CHR_LOWER_X, 1'b0, '0},
      '{nld_pkg::CHR_ZERO, 1'b0, '0},
      '{nld_pkg::CHR_POINT, 1'b0, '0},
      '{nld_pkg::CHR_UPPER_F, 1'b1, '{64'd0, 32'd0, 1'b1, nld_pkg::RADIX_DEC}}
   };

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_chr   = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_integer_value;
   logic [31:0] rsp_fraction;
   logic        rsp_has_point;
   logic [1:0]  rsp_radix_code;

   logic hold_rsp = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   int   stim_phase    = -1;

   int error_count      = 0;
   int chars_sent       = 0;
   int literals_checked = 0;
   int points_seen      = 0;
   int radix_seen [4]   = '{0, 0, 0, 0};
   int quiet_cycles     = 0;

   nld_pkg::nld_result_type literal_q [$];

   // Lexer state as the predictor sees it.
   logic [1:0]  lx_mode;
   logic [1:0]  lx_radix;
   logic [63:0] lx_int;
   logic [47:0] lx_frac;
   logic [48:0] lx_weight;

   numeric_literal_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_chr           (req_chr),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_integer_value (rsp_integer_value),
      .rsp_fraction      (rsp_fraction),
      .rsp_has_point     (rsp_has_point),
      .rsp_radix_code    (rsp_radix_code)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] radix_base(input logic [1:0] rdx);
      logic [63:0] b;
      case (rdx)
         nld_pkg::RADIX_DEC: b = 64'd10;
         nld_pkg::RADIX_HEX: b = 64'd16;
         nld_pkg::RADIX_OCT: b = 64'd8;
         default:            b = 64'd2;
      endcase
      return b;
   endfunction

   // Returns the digit value of c in the given radix, or -1 when c is no digit of it.
   function automatic int digit_of(input logic [7:0] c, input logic [1:0] rdx);
      int v;
      v = -1;
      if (c >= nld_pkg::CHR_ZERO && c <= nld_pkg::CHR_NINE) begin
         v = int'(c - nld_pkg::CHR_ZERO);
      end else if (c >= nld_pkg::CHR_LOWER_A && c <= nld_pkg::CHR_LOWER_F) begin
         v = int'(c - nld_pkg::CHR_LOWER_A) + 10;
      end else if (c >= nld_pkg::CHR_UPPER_A && c <= nld_pkg::CHR_UPPER_F) begin
         v = int'(c - nld_pkg::CHR_UPPER_A) + 10;
      end
      if (v >= int'(radix_base(rdx))) begin
         v = -1;
      end
      return v;
   endfunction

   function automatic logic [7:0] random_digit(input logic [1:0] rdx);
      int v;
      v = $urandom_range(int'(radix_base(rdx)) - 1);
      if (v < 10) begin
         return nld_pkg::CHR_ZERO + 8'(v);
      end
      return ($urandom_range(1) ? nld_pkg::CHR_LOWER_A : nld_pkg::CHR_UPPER_A) + 8'(v - 10);
   endfunction

   task automatic clear_literal();
      lx_radix  = nld_pkg::RADIX_DEC;
      lx_int    = '0;
      lx_frac   = '0;
      lx_weight = 49'(nld_pkg::ONE_Q48);
   endtask

   // One character through the lexer; emitted is set when a literal ends here.
   task automatic lex_step(input logic [7:0] c, output bit emitted,
                           output nld_pkg::nld_result_type res);
      int d;
      logic [63:0] base;
      emitted = 1'b0;
      res     = '0;
      if (lx_mode == nld_pkg::MODE_ZERO) begin
         lx_mode = nld_pkg::MODE_INT;
         if (c == nld_pkg::CHR_LOWER_X || c == nld_pkg::CHR_UPPER_X) begin
            lx_radix = nld_pkg::RADIX_HEX;
            return;
         end
         if (c == nld_pkg::CHR_LOWER_O || c == nld_pkg::CHR_UPPER_O) begin
            lx_radix = nld_pkg::RADIX_OCT;
            return;
         end
         if (c == nld_pkg::CHR_LOWER_B || c == nld_pkg::CHR_UPPER_B) begin
            lx_radix = nld_pkg::RADIX_BIN;
            return;
         end
         // The leading zero was a decimal digit; c continues the literal.
         lx_radix = nld_pkg::RADIX_DEC;
      end
      if (lx_mode == nld_pkg::MODE_INT || lx_mode == nld_pkg::MODE_FRAC) begin
         base = radix_base(lx_radix);
         d    = digit_of(c, lx_radix);
         if (d >= 0) begin
            if (lx_mode == nld_pkg::MODE_INT) begin
               lx_int = lx_int * base + 64'(d);
            end else begin
               lx_weight = 49'(lx_weight / base);
               lx_frac   = 48'(lx_frac + 64'(d) * lx_weight);
            end
            return;
         end
         if (lx_mode == nld_pkg::MODE_INT && c == nld_pkg::CHR_POINT) begin
            lx_mode   = nld_pkg::MODE_FRAC;
            lx_frac   = '0;
            lx_weight = 49'(nld_pkg::ONE_Q48);
            return;
         end
         res.integer_value = lx_int;
         res.has_point     = (lx_mode == nld_pkg::MODE_FRAC);
         res.fraction      = res.has_point ? lx_frac[47:16] : '0;
         res.radix_code    = lx_radix;
         emitted           = 1'b1;
         lx_mode           = nld_pkg::MODE_IDLE;
      end
      // The terminating character is looked at again as an idle input.
      if (c == nld_pkg::CHR_ZERO) begin
         clear_literal();
         lx_mode = nld_pkg::MODE_ZERO;
      end else if (c >= nld_pkg::CHR_ONE && c <= nld_pkg::CHR_NINE) begin
         clear_literal();
         lx_int  = 64'(c - nld_pkg::CHR_ZERO);
         lx_mode = nld_pkg::MODE_INT;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR %0t: %s: got %h, expected %h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // Offers one request, waits for it to be taken and queues what it should produce.
   task automatic send_char(input logic [7:0] c, input logic typed,
                            input nld_pkg::nld_result_type typed_res);
      bit emitted;
      nld_pkg::nld_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chr   <= c;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      lex_step(c, emitted, res);
      if (typed) begin
         literal_q.push_back(typed_res);
      end else if (emitted) begin
         literal_q.push_back(res);
      end
   endtask

   // Mostly well-formed literals with random content; some noise and cut-short prefixes.
   task automatic send_random_literal(output int n);
      int          form;
      int          ndig;
      int          nfrac;
      int          pick;
      logic [1:0]  rdx;
      logic [7:0]  term;
      n    = 0;
      form = $urandom_range(99);
      if (form < 8) begin
         repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255)), 1'b0, '0);
         return;
      end
      rdx = 2'($urandom_range(3));
      if ($urandom_range(99) < 8) begin
         // Long digit strings, many of them long enough to wrap the integer accumulator.
         ndig = (rdx == nld_pkg::RADIX_BIN) ? $urandom_range(70, 62) : $urandom_range(24, 17);
      end else begin
         ndig = $urandom_range(5);
      end
      if (rdx == nld_pkg::RADIX_DEC && $urandom_range(1)) begin
         send_char(nld_pkg::CHR_ONE + 8'($urandom_range(8)), 1'b0, '0);
      end else begin
         send_char(nld_pkg::CHR_ZERO, 1'b0, '0);
         case (rdx)
            nld_pkg::RADIX_HEX:
               send_char($urandom_range(1) ? nld_pkg::CHR_LOWER_X : nld_pkg::CHR_UPPER_X,
                         1'b0, '0);
            nld_pkg::RADIX_OCT:
               send_char($urandom_range(1) ? nld_pkg::CHR_LOWER_O : nld_pkg::CHR_UPPER_O,
                         1'b0, '0);
            nld_pkg::RADIX_BIN:
               send_char($urandom_range(1) ? nld_pkg::CHR_LOWER_B : nld_pkg::CHR_UPPER_B,
                         1'b0, '0);
            default: ;
         endcase
         n++;
      end
      n++;
      repeat (ndig) send_char(random_digit(rdx), 1'b0, '0);
      n += ndig;
      if ($urandom_range(99) < 40) begin
         send_char(nld_pkg::CHR_POINT, 1'b0, '0);
         // Now and then enough fraction digits to run the weight down to zero.
         nfrac = ($urandom_range(99) < 6) ? $urandom_range(52, 14) : $urandom_range(6);
         repeat (nfrac) send_char(random_digit(rdx), 1'b0, '0);
         n += nfrac + 1;
      end
      pick = $urandom_range(6);
      case (pick)
         0:       term = CHR_SPACE;
         1:       term = CHR_SEMI;
         2:       term = nld_pkg::CHR_POINT;
         3:       term = 8'($urandom_range(CHR_LOWER_Z, CHR_LOWER_G));
         4:       term = 8'($urandom_range(255));
         5:       term = nld_pkg::CHR_ZERO + 8'($urandom_range(9));
         default: term = nld_pkg::CHR_UPPER_A + 8'($urandom_range(5));
      endcase
      send_char(term, 1'b0, '0);
      n++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Long receiver hold-off while the sender keeps offering requests.
   initial begin
      wait (stim_phase == 2);
      repeat (50) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin : check_literals
      nld_pkg::nld_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (literal_q.size() == 0) begin
            report_mismatch("result with no literal pending", rsp_integer_value, 64'd0);
         end else begin
            want = literal_q.pop_front();
            if (rsp_integer_value !== want.integer_value)
               report_mismatch("integer_value", rsp_integer_value, want.integer_value);
            if (rsp_fraction !== want.fraction)
               report_mismatch("fraction", 64'(rsp_fraction), 64'(want.fraction));
            if (rsp_has_point !== want.has_point)
               report_mismatch("has_point", 64'(rsp_has_point), 64'(want.has_point));
            if (rsp_radix_code !== want.radix_code)
               report_mismatch("radix_code", 64'(rsp_radix_code), 64'(want.radix_code));
            literals_checked++;
            radix_seen[want.radix_code]++;
            if (want.has_point) points_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int n;
      int phase_chars;
      lx_mode = nld_pkg::MODE_IDLE;
      clear_literal();
      repeat (3) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 30;
      rsp_idle_pct  <= 58;
      stim_phase    <= 0;

      foreach (DIRECTED_ROWS[i]) begin
         send_char(DIRECTED_ROWS[i].chr, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end

      for (int ph = 0; ph < 3; ph++) begin
         stim_phase    <= ph;
         send_idle_pct <= (ph == 0) ? 30 : (ph == 1) ? 58 : 0;
         rsp_idle_pct  <= (ph == 0) ? 58 : (ph == 1) ? 30 : 0;
         phase_chars = 0;
         while (phase_chars < CHARS_PER_PHASE) begin
            send_random_literal(n);
            phase_chars += n;
         end
      end
      // A last separator closes whatever literal is still open.
      send_char(CHR_SPACE, 1'b0, '0);
      req_valid <= 1'b0;

      while (literal_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Run covered %0d characters and %0d literals:", chars_sent, literals_checked);
      $display("%0d decimal, %0d hex, %0d octal, %0d binary; %0d with a fraction; %0s %0d cycles.",
               radix_seen[nld_pkg::RADIX_DEC], radix_seen[nld_pkg::RADIX_HEX],
               radix_seen[nld_pkg::RADIX_OCT], radix_seen[nld_pkg::RADIX_BIN],
               points_seen, "one receiver stall of", HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/nld_pkg.sv
sv/nld_core.sv
sv/numeric_literal_decoder.sv
tb/sv/numeric_literal_decoder_tb.sv
